// ----- src/rms_audio_level_meter_core_assert.svh -----
// ----------------------------------------------------------------------------
// RMS level meter assertion macros
// Concurrent assertion helpers used by the level meter core.
// ----------------------------------------------------------------------------
`ifndef RMS_AUDIO_LEVEL_METER_CORE_ASSERT_SVH
`define RMS_AUDIO_LEVEL_METER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RMSM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("level meter assertion failed");
`define RMSM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("level meter assertion failed");
`else
`define RMSM_ASSERT_IMP(label, clk, rst, ante, cons)
`define RMSM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/rmsm_pkg.sv -----
// ----------------------------------------------------------------------------
// RMS level meter package
// Item kinds, register indexes, fixed widths, step limits and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmsm_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_SILENCE = 2'd1,
    KIND_REPORT  = 2'd2
  } kind_t;

  localparam logic REG_LEVEL_OFFSET = 1'b0;
  localparam logic REG_LEVEL_GAIN   = 1'b1;

  localparam int SUM_BITS    = 50;
  localparam int ROOT_BITS   = 25;
  localparam int OFFSET_BITS = 15;
  localparam int GAIN_BITS   = 12;
  localparam int PROD_BITS   = ROOT_BITS + GAIN_BITS;
  localparam int LEVEL_BITS  = 16;
  localparam int WCOUNT_BITS = 20;
  localparam int STEP_BITS   = 6;

  localparam logic [STEP_BITS-1:0] DIV_LAST  = 6'd49;
  localparam logic [STEP_BITS-1:0] SQRT_LAST = 6'd24;

  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 15'd82;
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 12'd1920;
  localparam logic [LEVEL_BITS-1:0]  FULL_SCALE   = 16'd32768;
  localparam logic [WCOUNT_BITS-1:0] WCOUNT_MAX   = 20'hFFFFF;

endpackage

// ----- src/rmsm_front.sv -----
// ----------------------------------------------------------------------------
// RMS level meter front end
// Accumulates squared samples and the sample count, and hands a window
// snapshot to the report queue on each report item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmsm_front #(
  parameter int COUNT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [15:0]                   in_sample,
  input  logic [15:0]                   in_run_length,
  output logic                          push,
  input  logic                          push_ready,
  output logic [rmsm_pkg::SUM_BITS-1:0] win_sum,
  output logic [COUNT_BITS-1:0]         win_count
);

  localparam int AW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int SW = rmsm_pkg::SUM_BITS + 1;

  rmsm_pkg::kind_t kind;
  logic                          accept;
  logic [15:0]                   mag;
  logic [31:0]                   square;
  logic [SW-1:0]                 sum_add;
  logic [AW-1:0]                 count_add;
  logic [AW-1:0]                 count_inc;
  logic [AW-1:0]                 count_max;
  logic [rmsm_pkg::SUM_BITS-1:0] sum_next;
  logic [COUNT_BITS-1:0]         count_next;

  assign kind      = rmsm_pkg::kind_t'(in_kind);
  assign in_ready  = (kind != rmsm_pkg::KIND_REPORT) || push_ready;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (kind == rmsm_pkg::KIND_REPORT);
  assign count_max = AW'({COUNT_BITS{1'b1}});

  always_comb begin
    mag       = in_sample[15] ? 16'(~in_sample + 16'd1) : in_sample;
    square    = 32'(mag) * 32'(mag);
    sum_add   = SW'(win_sum) + SW'(square);
    count_inc = (kind == rmsm_pkg::KIND_SAMPLE) ? AW'(1) : AW'(in_run_length);
    count_add = AW'(win_count) + count_inc;
    sum_next   = win_sum;
    count_next = win_count;
    unique case (kind)
      rmsm_pkg::KIND_SAMPLE: begin
        sum_next   = sum_add[SW-1] ? {rmsm_pkg::SUM_BITS{1'b1}} : sum_add[SW-2:0];
        count_next = (count_add > count_max) ? {COUNT_BITS{1'b1}} : count_add[COUNT_BITS-1:0];
      end
      rmsm_pkg::KIND_SILENCE: begin
        count_next = (count_add > count_max) ? {COUNT_BITS{1'b1}} : count_add[COUNT_BITS-1:0];
      end
      rmsm_pkg::KIND_REPORT: begin
        sum_next   = '0;
        count_next = '0;
      end
      default: begin
        sum_next   = win_sum;
        count_next = win_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum   <= '0;
      win_count <= '0;
    end else if (accept) begin
      win_sum   <= sum_next;
      win_count <= count_next;
    end
  end

endmodule

// ----- src/rmsm_fifo.sv -----
// ----------------------------------------------------------------------------
// RMS level meter report queue
// Two-entry queue of window snapshots between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmsm_fifo #(
  parameter int WIDTH = 70
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- src/rmsm_back.sv -----
// ----------------------------------------------------------------------------
// RMS level meter back end
// Serial divide, serial square root, offset and gain, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmsm_back #(
  parameter int COUNT_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rmsm_pkg::SUM_BITS-1:0]    in_sum,
  input  logic [COUNT_BITS-1:0]            in_count,
  input  logic [rmsm_pkg::OFFSET_BITS-1:0] level_offset,
  input  logic [rmsm_pkg::GAIN_BITS-1:0]   level_gain,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rmsm_pkg::LEVEL_BITS-1:0]  out_level,
  output logic [rmsm_pkg::WCOUNT_BITS-1:0] out_window_count
);

  localparam int SB = rmsm_pkg::SUM_BITS;
  localparam int RB = rmsm_pkg::ROOT_BITS;
  localparam int PB = rmsm_pkg::PROD_BITS;
  localparam int QB = RB + 2;
  localparam int WB = (COUNT_BITS > rmsm_pkg::WCOUNT_BITS) ? COUNT_BITS : rmsm_pkg::WCOUNT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t                         state;
  logic [SB-1:0]                  dvd;
  logic [COUNT_BITS-1:0]          divisor;
  logic [COUNT_BITS-1:0]          div_rem;
  logic [QB-1:0]                  sq_rem;
  logic [RB-1:0]                  root;
  logic [PB-1:0]                  prod;
  logic [rmsm_pkg::STEP_BITS-1:0] step;

  logic [COUNT_BITS:0]            div_sh;
  logic                           div_ge;
  logic [QB+1:0]                  sq_sh;
  logic [QB+1:0]                  sq_trial;
  logic                           sq_ge;
  logic [PB-9:0]                  scaled;
  logic [rmsm_pkg::LEVEL_BITS-1:0] level_next;
  logic [WB-1:0]                  count_ext;
  logic [rmsm_pkg::WCOUNT_BITS-1:0] wcount_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    div_sh     = {div_rem, dvd[SB-1]};
    div_ge     = div_sh >= {1'b0, divisor};
    sq_sh      = {sq_rem, dvd[SB-1:SB-2]};
    sq_trial   = (QB+2)'({root, 2'b01});
    sq_ge      = sq_sh >= sq_trial;
    scaled     = prod[PB-1:8];
    level_next = (scaled > (PB-8)'(rmsm_pkg::FULL_SCALE)) ? rmsm_pkg::FULL_SCALE :
                 scaled[rmsm_pkg::LEVEL_BITS-1:0];
    count_ext  = WB'(divisor);
    wcount_next = (count_ext > WB'(rmsm_pkg::WCOUNT_MAX)) ? rmsm_pkg::WCOUNT_MAX :
                  count_ext[rmsm_pkg::WCOUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dvd     <= in_sum;
            divisor <= in_count;
            div_rem <= '0;
            sq_rem  <= '0;
            root    <= '0;
            step    <= '0;
            state   <= (in_count == '0) ? ST_MUL : ST_DIV;
          end
        end
        ST_DIV: begin
          div_rem <= div_ge ? COUNT_BITS'(div_sh - {1'b0, divisor}) : div_sh[COUNT_BITS-1:0];
          dvd     <= {dvd[SB-2:0], div_ge};
          if (step == rmsm_pkg::DIV_LAST) begin
            step  <= '0;
            state <= ST_SQRT;
          end else begin
            step  <= step + rmsm_pkg::STEP_BITS'(1);
          end
        end
        ST_SQRT: begin
          sq_rem <= sq_ge ? QB'(sq_sh - sq_trial) : sq_sh[QB-1:0];
          root   <= {root[RB-2:0], sq_ge};
          dvd    <= {dvd[SB-3:0], 2'b00};
          step   <= step + rmsm_pkg::STEP_BITS'(1);
          if (step == rmsm_pkg::SQRT_LAST) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (root > RB'(level_offset)) begin
            prod <= PB'(root - RB'(level_offset)) * PB'(level_gain);
          end else begin
            prod <= '0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_level        <= level_next;
            out_window_count <= wcount_next;
            out_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/rms_audio_level_meter_core.sv -----
// ----------------------------------------------------------------------------
// RMS audio level meter core
// Accumulates sample energy over a window and reports a scaled RMS level.
// ----------------------------------------------------------------------------
// The slave channel takes one item per transfer: tuser holds the kind
// (sample, silent run, report) and tdata holds the sample and run length.
// Sample and silent-run items are taken one per cycle and give no result.
// A report item snapshots the window, clears it in the same cycle, and
// queues the snapshot in a two-entry queue, so accumulation continues
// at once. The back end works one report at a time: a 50-step serial
// divider, a 25-step serial square root (both skipped if the count is 0),
// a multiply step and an output step that waits for the receiver; it takes
// the next report only after its last result is registered. The slave side
// stalls only on a report item while the queue holds two reports.
// The master channel holds its result in a register; while the receiver
// stalls, the back end still computes the next report and then waits.
// Configuration writes (offset, gain) are taken in any cycle and belong
// to idle periods. Reset clears the window, the queue and the result valid
// flag, and loads the default offset and gain.
`timescale 1ns / 1ps

`include "rms_audio_level_meter_core_assert.svh"

module rms_audio_level_meter_core #(
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample [15:0], run_length [31:16]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // level [15:0], window_count [35:16], zero [39:36]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int QW = rmsm_pkg::SUM_BITS + COUNT_BITS;

  logic [rmsm_pkg::OFFSET_BITS-1:0] level_offset;
  logic [rmsm_pkg::GAIN_BITS-1:0]   level_gain;
  logic                             push;
  logic                             push_ready;
  logic [rmsm_pkg::SUM_BITS-1:0]    win_sum;
  logic [COUNT_BITS-1:0]            win_count;
  logic                             pop_valid;
  logic                             pop;
  logic [QW-1:0]                    pop_data;
  logic [rmsm_pkg::LEVEL_BITS-1:0]  out_level;
  logic [rmsm_pkg::WCOUNT_BITS-1:0] out_window_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_offset <= rmsm_pkg::OFFSET_RESET;
      level_gain   <= rmsm_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rmsm_pkg::REG_LEVEL_OFFSET) begin
        level_offset <= cfg_data;
      end
      if (cfg_index == rmsm_pkg::REG_LEVEL_GAIN) begin
        level_gain <= cfg_data[rmsm_pkg::GAIN_BITS-1:0];
      end
    end
  end

  rmsm_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_kind       (s_tuser),
    .in_sample     (s_tdata[15:0]),
    .in_run_length (s_tdata[31:16]),
    .push          (push),
    .push_ready    (push_ready),
    .win_sum       (win_sum),
    .win_count     (win_count)
  );

  rmsm_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  ({win_count, win_sum}),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  rmsm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (pop_valid),
    .in_ready         (pop),
    .in_sum           (pop_data[rmsm_pkg::SUM_BITS-1:0]),
    .in_count         (pop_data[QW-1:rmsm_pkg::SUM_BITS]),
    .level_offset     (level_offset),
    .level_gain       (level_gain),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_level        (out_level),
    .out_window_count (out_window_count)
  );

  assign m_tdata = {4'b0000, out_window_count, out_level};

  `RMSM_ASSERT_IMP(a_push_room, clk, rst, push, push_ready)
  `RMSM_ASSERT_NXT(a_report_clears, clk, rst,
    s_tvalid && s_tready && (s_tuser == rmsm_pkg::KIND_REPORT),
    (win_sum == '0) && (win_count == '0))
  `RMSM_ASSERT_IMP(a_level_range, clk, rst, m_tvalid, out_level <= rmsm_pkg::FULL_SCALE)
  `RMSM_ASSERT_IMP(a_stall_report, clk, rst,
    s_tvalid && !s_tready, (s_tuser == rmsm_pkg::KIND_REPORT) && !push_ready)

endmodule
